/* sv/lsct_pkg.sv */
// Package for the LFU slot cache tag store.
// Holds sizes, derived widths and the store access types; no dependencies.
package lsct_pkg;

  localparam int SLOTS          = 8;
  localparam int KEY_BITS       = 32;
  localparam int COUNT_BITS     = 16;
  localparam int KEY_FIELD_BITS = 32;
  localparam int SLOT_FIELD_BITS = 3;
  localparam int SLOT_BITS      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MIN_START_BITS = 31;
  localparam int BEST_BITS      = (COUNT_BITS > MIN_START_BITS) ? COUNT_BITS : MIN_START_BITS;
  localparam logic [BEST_BITS-1:0] MIN_START = BEST_BITS'(32'h7FFF_FFFF);

  typedef logic [SLOT_BITS-1:0]  slot_idx_t;
  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // Write request from the sequencer to the store
  typedef struct packed {
    logic      we;
    logic      clr;
    slot_idx_t idx;
    key_t      key;
    count_t    count;
  } store_wr_t;

  // Contents of the addressed slot
  typedef struct packed {
    logic   valid;
    key_t   key;
    count_t count;
  } store_rd_t;

endpackage

/* sv/lsct_store.sv */
// Slot store: valid bits, keys and use counts, one read and one write address.
// Depends on lsct_pkg.
module lsct_store (
  input  logic                clk,
  input  logic                rst_n,
  input  lsct_pkg::slot_idx_t rd_idx,
  output lsct_pkg::store_rd_t rd,
  input  lsct_pkg::store_wr_t wr
);
  import lsct_pkg::*;

  logic   valid_r [SLOTS];
  key_t   key_r   [SLOTS];
  count_t count_r [SLOTS];

  // Valid bits reset and clear at once; keys and counts of empty slots are never used
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) valid_r[i] <= 1'b0;
    end else if (wr.clr) begin
      for (int i = 0; i < SLOTS; i++) valid_r[i] <= 1'b0;
    end else if (wr.we) begin
      valid_r[wr.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we && !wr.clr) begin
      key_r[wr.idx]   <= wr.key;
      count_r[wr.idx] <= wr.count;
    end
  end

  assign rd.valid = valid_r[rd_idx];
  assign rd.key   = key_r[rd_idx];
  assign rd.count = count_r[rd_idx];

endmodule

/* sv/lsct_seq.sv */
// Sequencer with the shared key/count compare unit and the result register.
// Walks one slot per cycle, then does a write-back step. Depends on lsct_pkg.
module lsct_seq (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_command,
  input  logic [lsct_pkg::KEY_FIELD_BITS-1:0]  in_key,
  input  logic                                 in_open_ok,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_hit,
  output logic [lsct_pkg::SLOT_FIELD_BITS-1:0] out_slot,
  output logic                                 out_installed,
  output logic                                 out_evicted,
  output logic [lsct_pkg::KEY_FIELD_BITS-1:0]  out_evicted_key,
  output logic                                 out_failed,
  output lsct_pkg::slot_idx_t                  rd_idx,
  input  lsct_pkg::store_rd_t                  rd,
  output lsct_pkg::store_wr_t                  wr
);
  import lsct_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WRITE} state_t;
  typedef enum logic [1:0] {OP_HIT, OP_INSTALL, OP_FAIL, OP_CLEAR} op_t;

  localparam slot_idx_t LAST_IDX = SLOT_BITS'(SLOTS - 1);

  state_t                       state_r, state_nxt;
  op_t                          op_r, op_nxt;
  slot_idx_t                    idx_r, idx_nxt;
  slot_idx_t                    tgt_r, tgt_nxt;
  slot_idx_t                    empty_r, empty_nxt;
  slot_idx_t                    victim_r, victim_nxt;
  logic                         have_empty_r, have_empty_nxt;
  logic [BEST_BITS-1:0]         best_r, best_nxt;
  key_t                         key_r, key_nxt;
  logic                         open_ok_r, open_ok_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic                         hit_r, hit_nxt;
  logic [SLOT_FIELD_BITS-1:0]   slot_r, slot_nxt;
  logic                         installed_r, installed_nxt;
  logic                         evicted_r, evicted_nxt;
  logic [KEY_FIELD_BITS-1:0]    evicted_key_r, evicted_key_nxt;
  logic                         failed_r, failed_nxt;

  logic                         key_eq;
  logic                         cnt_less;
  logic                         out_free;
  logic [SLOT_BITS+SLOT_FIELD_BITS-1:0] slot_wide;

  // Shared compare unit: one slot per cycle
  assign key_eq   = rd.valid && (rd.key == key_r);
  assign cnt_less = BEST_BITS'(rd.count) < best_r;
  assign out_free = !out_valid_r || !out_stall;
  assign rd_idx   = (state_r == S_WRITE) ? tgt_r : idx_r;
  assign slot_wide = (SLOT_BITS + SLOT_FIELD_BITS)'(tgt_r);

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    idx_nxt         = idx_r;
    tgt_nxt         = tgt_r;
    empty_nxt       = empty_r;
    victim_nxt      = victim_r;
    have_empty_nxt  = have_empty_r;
    best_nxt        = best_r;
    key_nxt         = key_r;
    open_ok_nxt     = open_ok_r;
    out_valid_nxt   = out_valid_r && out_stall;
    hit_nxt         = hit_r;
    slot_nxt        = slot_r;
    installed_nxt   = installed_r;
    evicted_nxt     = evicted_r;
    evicted_key_nxt = evicted_key_r;
    failed_nxt      = failed_r;
    wr              = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt        = in_key[KEY_BITS-1:0];
          open_ok_nxt    = in_open_ok;
          idx_nxt        = '0;
          have_empty_nxt = 1'b0;
          empty_nxt      = '0;
          victim_nxt     = '0;
          best_nxt       = MIN_START;
          if (in_command) begin
            op_nxt    = OP_CLEAR;
            state_nxt = S_WRITE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (key_eq) begin
          op_nxt    = OP_HIT;
          tgt_nxt   = idx_r;
          state_nxt = S_WRITE;
        end else begin
          if (!rd.valid && !have_empty_r) begin
            have_empty_nxt = 1'b1;
            empty_nxt      = idx_r;
          end
          if (cnt_less) begin
            best_nxt   = BEST_BITS'(rd.count);
            victim_nxt = idx_r;
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = S_WRITE;
            if (!open_ok_r) begin
              op_nxt = OP_FAIL;
            end else begin
              op_nxt  = OP_INSTALL;
              tgt_nxt = have_empty_nxt ? empty_nxt : victim_nxt;
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      S_WRITE: begin
        // Hold here while the previous result is still waiting
        if (out_free) begin
          state_nxt       = S_IDLE;
          out_valid_nxt   = 1'b1;
          hit_nxt         = 1'b0;
          slot_nxt        = '0;
          installed_nxt   = 1'b0;
          evicted_nxt     = 1'b0;
          evicted_key_nxt = '0;
          failed_nxt      = 1'b0;
          wr.idx          = tgt_r;
          unique case (op_r)
            OP_HIT: begin
              hit_nxt  = 1'b1;
              slot_nxt = slot_wide[SLOT_FIELD_BITS-1:0];
              wr.we    = 1'b1;
              wr.key   = rd.key;
              wr.count = (&rd.count) ? rd.count : rd.count + 1'b1;
            end
            OP_INSTALL: begin
              installed_nxt = 1'b1;
              slot_nxt      = slot_wide[SLOT_FIELD_BITS-1:0];
              evicted_nxt   = rd.valid;
              if (rd.valid) evicted_key_nxt = KEY_FIELD_BITS'(rd.key);
              wr.we    = 1'b1;
              wr.key   = key_r;
              wr.count = COUNT_BITS'(1);
            end
            OP_FAIL: begin
              failed_nxt = 1'b1;
            end
            OP_CLEAR: begin
              wr.clr = 1'b1;
            end
            default: begin
              failed_nxt = 1'b0;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r          <= op_nxt;
    idx_r         <= idx_nxt;
    tgt_r         <= tgt_nxt;
    empty_r       <= empty_nxt;
    victim_r      <= victim_nxt;
    have_empty_r  <= have_empty_nxt;
    best_r        <= best_nxt;
    key_r         <= key_nxt;
    open_ok_r     <= open_ok_nxt;
    hit_r         <= hit_nxt;
    slot_r        <= slot_nxt;
    installed_r   <= installed_nxt;
    evicted_r     <= evicted_nxt;
    evicted_key_r <= evicted_key_nxt;
    failed_r      <= failed_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_hit         = hit_r;
  assign out_slot        = slot_r;
  assign out_installed   = installed_r;
  assign out_evicted     = evicted_r;
  assign out_evicted_key = evicted_key_r;
  assign out_failed      = failed_r;

endmodule

/* sv/lfu_slot_cache_tags_core.sv */
// Tag store of a small fully associative cache with least-frequently-used replacement.
// Top level: instantiates lsct_seq and lsct_store; depends on lsct_pkg.
//
// Input channel (in_valid / in_stall): command (0 lookup/install, 1 invalidate all),
// key and open_ok. Result channel (out_valid / out_stall): hit, slot, installed,
// evicted, evicted_key, failed; exactly one result per input transaction.
// A lookup walks the slots one per cycle through a single compare unit, stopping
// at the first valid slot with an equal key, then does a write-back step that
// updates the count of a hit, installs the key on a miss with open_ok set, or
// reports failed on a miss without it. A miss scans all 8 slots; an invalidate
// skips the scan. The next transaction is taken on the cycle after the result is
// registered; in_stall is high while a transaction is in flight.
// The result register lets a new transaction be accepted while the previous result
// waits; if the receiver stalls, the next transaction holds in its write-back cycle
// until the result register is free. Synchronous reset (rst_n low) empties every
// slot and drops any pending result.
module lfu_slot_cache_tags_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_command,
  input  logic [lsct_pkg::KEY_FIELD_BITS-1:0]  in_key,
  input  logic                                 in_open_ok,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_hit,
  output logic [lsct_pkg::SLOT_FIELD_BITS-1:0] out_slot,
  output logic                                 out_installed,
  output logic                                 out_evicted,
  output logic [lsct_pkg::KEY_FIELD_BITS-1:0]  out_evicted_key,
  output logic                                 out_failed
);
  import lsct_pkg::*;

  slot_idx_t rd_idx;
  store_rd_t rd;
  store_wr_t wr;

  lsct_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_key          (in_key),
    .in_open_ok      (in_open_ok),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_slot        (out_slot),
    .out_installed   (out_installed),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key),
    .out_failed      (out_failed),
    .rd_idx          (rd_idx),
    .rd              (rd),
    .wr              (wr)
  );

  lsct_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (rd_idx),
    .rd     (rd),
    .wr     (wr)
  );

endmodule

/* sv/lsct_checker.sv */
// Port-level checker for lfu_slot_cache_tags_core, with its bind statement.
// Depends on lsct_pkg.
module lsct_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic                                 out_hit,
  input logic [lsct_pkg::SLOT_FIELD_BITS-1:0] out_slot,
  input logic                                 out_installed,
  input logic                                 out_evicted,
  input logic [lsct_pkg::KEY_FIELD_BITS-1:0]  out_evicted_key,
  input logic                                 out_failed
);
  import lsct_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // One transaction at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a transaction is in flight");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_hit, out_installed, out_failed}))
    else $error("more than one outcome in a result");

  a_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> out_installed)
    else $error("eviction without install");

  a_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_failed |-> (out_slot == '0) && (out_evicted_key == '0) && !out_evicted)
    else $error("failed result carries data");

endmodule

bind lfu_slot_cache_tags_core lsct_checker u_lsct_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_hit         (out_hit),
  .out_slot        (out_slot),
  .out_installed   (out_installed),
  .out_evicted     (out_evicted),
  .out_evicted_key (out_evicted_key),
  .out_failed      (out_failed)
);
